FILE: hdl/gcvs_pkg.sv
`timescale 1ns / 1ps
// gcvs_pkg: shared types, codes and helpers for the gc victim selector
// no dependencies; imported by the divider, datapath, controller and top level

package gcvs_pkg;

    // fixed field widths
    localparam int AREA_W    = 10;
    localparam int TYPE_W    = 2;
    localparam int COUNT32_W = 32;
    localparam int SUM_W     = 64;
    localparam int ACNT_W    = 11;
    localparam int DIRTY_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int MAX_PAGES = 32;

    // area type codes
    localparam logic [TYPE_W-1:0] TYPE_UNSET = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_DATA  = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_INDEX = 2'd2;

    // page summary codes
    localparam logic [1:0] PAGE_USED  = 2'd1;
    localparam logic [1:0] PAGE_DIRTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERALL_DEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_COUNT  = 2'd2;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_LOAD_ERR = 1'b1;

    // configuration reset values
    localparam logic [TYPE_W-1:0]    TARGET_RESET = TYPE_DATA;
    localparam logic [ACNT_W-1:0]    ACOUNT_RESET = 11'd1024;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic eval;
    } gcvs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic emit;
    } gcvs_status_t;

    // mask that keeps the codes of the first pages pages
    function automatic logic [SUM_W-1:0] page_mask(input int pages);
        logic [SUM_W-1:0] m;
        m = '0;
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            if (p < pages)
            begin
                m[2*p +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

endpackage

FILE: hdl/gcvs_div.sv
`timescale 1ns / 1ps
// gcvs_div: radix-2 restoring divider for the wear average quotient
// uses gcvs_pkg for widths; one quotient bit per cycle

module gcvs_div
    import gcvs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [COUNT32_W-1:0] dividend,
    input  logic [ACNT_W-1:0]    divisor,
    output logic                 busy,
    output logic [COUNT32_W-1:0] quotient
);

    logic [ACNT_W:0]      rem_reg;
    logic [COUNT32_W-1:0] quo_reg;
    logic [ACNT_W-1:0]    dvs_reg;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;

    logic [ACNT_W:0]      shifted;
    logic                 fits;

    // one restoring step; zero divisor always fits, giving all ones
    assign shifted = {rem_reg[ACNT_W-1:0], quo_reg[COUNT32_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg  <= {quo_reg[COUNT32_W-2:0], fits};
            cnt_reg  <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/gcvs_datapath.sv
`timescale 1ns / 1ps
// gcvs_datapath: config registers, item registers, page counting, best-area tracking
// uses gcvs_pkg and instantiates gcvs_div

module gcvs_datapath
    import gcvs_pkg::*;
#(
    parameter int PAGES_PER_AREA = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcvs_cmd_t            cmd,
    output gcvs_status_t         st,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [AREA_W-1:0]    area_index,
    input  logic                 is_active,
    input  logic [TYPE_W-1:0]    area_type,
    input  logic [COUNT32_W-1:0] erase_count,
    input  logic [SUM_W-1:0]     page_summary,
    input  logic                 summary_written,
    input  logic                 should_clear,
    input  logic                 load_error,
    input  logic                 last_area,
    output logic [AREA_W-1:0]    victim_area,
    output logic                 has_valid_data,
    output logic [SUM_W-1:0]     victim_summary,
    output logic                 status
);

    localparam logic [SUM_W-1:0]   PageMask  = page_mask(PAGES_PER_AREA);
    localparam logic [DIRTY_W-1:0] FullDirty = DIRTY_W'(PAGES_PER_AREA);

    // configuration
    logic [TYPE_W-1:0]    target_reg;
    logic [COUNT32_W-1:0] odel_reg;
    logic [ACNT_W-1:0]    acount_reg;
    logic                 div_start_reg;
    logic                 div_busy;
    logic [COUNT32_W-1:0] quot;

    // item registers
    logic [AREA_W-1:0]    area_reg;
    logic                 active_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic [COUNT32_W-1:0] erases_reg;
    logic [SUM_W-1:0]     summary_reg;
    logic                 written_reg;
    logic                 clear_reg;
    logic                 lerr_reg;
    logic                 last_reg;

    // scan state
    logic [AREA_W-1:0]    best_area_reg,    best_area_next;
    logic [DIRTY_W-1:0]   best_dirty_reg,   best_dirty_next;
    logic [COUNT32_W-1:0] best_erases_reg,  best_erases_next;
    logic                 best_valid_reg,   best_valid_next;
    logic [SUM_W-1:0]     best_summary_reg, best_summary_next;
    logic                 decided_reg,      decided_next;

    // result registers
    logic [AREA_W-1:0]    victim_area_reg;
    logic                 has_valid_reg;
    logic [SUM_W-1:0]     victim_summary_reg;
    logic                 status_reg;

    logic [DIRTY_W-1:0]   dirty;
    logic                 any_used;
    logic                 candidate;
    logic                 wear_ok;
    logic                 update;
    logic                 restart;
    logic                 emit;
    logic [AREA_W-1:0]    e_area;
    logic                 e_valid;
    logic [SUM_W-1:0]     e_sum;
    logic                 e_status;

    // configuration writes; any write restarts the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            odel_reg      <= '0;
            acount_reg    <= ACOUNT_RESET;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET_TYPE: target_reg <= cfg_data[TYPE_W-1:0];
                    REG_OVERALL_DEL: odel_reg   <= cfg_data;
                    REG_AREA_COUNT:  acount_reg <= cfg_data[ACNT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // wear average quotient, recomputed after every config write
    gcvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (odel_reg),
        .divisor  (acount_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            area_reg    <= area_index;
            active_reg  <= is_active;
            type_reg    <= area_type;
            erases_reg  <= erase_count;
            summary_reg <= page_summary & PageMask;
            written_reg <= summary_written;
            clear_reg   <= should_clear;
            lerr_reg    <= load_error;
            last_reg    <= last_area;
        end
    end

    // page counting over the masked summary
    always_comb
    begin
        dirty    = '0;
        any_used = 1'b0;
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            if (summary_reg[2*p +: 2] == PAGE_DIRTY)
            begin
                dirty = dirty + DIRTY_W'(1);
            end
            if (summary_reg[2*p +: 2] == PAGE_USED)
            begin
                any_used = 1'b1;
            end
        end
    end

    assign candidate = !active_reg && (type_reg == TYPE_DATA || type_reg == TYPE_INDEX);
    assign wear_ok   = (odel_reg < {{(COUNT32_W-ACNT_W){1'b0}}, acount_reg})
                       || (erases_reg < quot);

    // decision for the item held in the item registers
    always_comb
    begin
        best_area_next    = best_area_reg;
        best_dirty_next   = best_dirty_reg;
        best_erases_next  = best_erases_reg;
        best_valid_next   = best_valid_reg;
        best_summary_next = best_summary_reg;
        decided_next      = decided_reg;
        update            = 1'b0;
        restart           = 1'b0;
        emit              = 1'b0;
        e_area            = best_area_reg;
        e_valid           = best_valid_reg;
        e_sum             = best_summary_reg;
        e_status          = STATUS_OK;
        if (cmd.eval)
        begin
            if (decided_reg)
            begin
                // wait for the end of the scan
                restart = last_reg;
            end
            else if (candidate && lerr_reg)
            begin
                emit     = 1'b1;
                e_area   = '0;
                e_valid  = 1'b0;
                e_sum    = '0;
                e_status = STATUS_LOAD_ERR;
                restart      = last_reg;
                decided_next = !last_reg;
            end
            else if (candidate && target_reg != TYPE_UNSET && dirty == FullDirty && wear_ok)
            begin
                // fully dirty area ends the scan early
                emit     = 1'b1;
                e_area   = area_reg;
                e_valid  = 1'b0;
                e_sum    = summary_reg;
                e_status = STATUS_OK;
                restart      = last_reg;
                decided_next = !last_reg;
            end
            else
            begin
                if (candidate)
                begin
                    if (target_reg != TYPE_UNSET)
                    begin
                        update = (type_reg == target_reg)
                                 && ((dirty > best_dirty_reg)
                                     || (dirty != '0 && dirty == best_dirty_reg
                                         && (erases_reg < best_erases_reg || written_reg)));
                        if (update)
                        begin
                            best_erases_next = erases_reg;
                        end
                    end
                    else
                    begin
                        update = clear_reg && (dirty >= best_dirty_reg);
                    end
                end
                if (update)
                begin
                    best_area_next    = area_reg;
                    best_dirty_next   = dirty;
                    best_valid_next   = any_used;
                    best_summary_next = summary_reg;
                end
                if (last_reg)
                begin
                    emit     = 1'b1;
                    e_area   = best_area_next;
                    e_valid  = best_valid_next;
                    e_sum    = best_summary_next;
                    e_status = STATUS_OK;
                    restart  = 1'b1;
                end
            end
            if (restart)
            begin
                best_area_next    = '0;
                best_dirty_next   = '0;
                best_erases_next  = '1;
                best_valid_next   = 1'b0;
                best_summary_next = '0;
                decided_next      = 1'b0;
            end
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_area_reg   <= '0;
            best_dirty_reg  <= '0;
            best_erases_reg <= '1;
            best_valid_reg  <= 1'b0;
            decided_reg     <= 1'b0;
        end
        else
        begin
            best_area_reg   <= best_area_next;
            best_dirty_reg  <= best_dirty_next;
            best_erases_reg <= best_erases_next;
            best_valid_reg  <= best_valid_next;
            decided_reg     <= decided_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_summary_reg <= best_summary_next;
    end

    // result beat registers
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            victim_area_reg    <= e_area;
            has_valid_reg      <= e_valid;
            victim_summary_reg <= e_sum;
            status_reg         <= e_status;
        end
    end

    assign st.div_busy     = div_start_reg || div_busy;
    assign st.emit         = emit;
    assign victim_area     = victim_area_reg;
    assign has_valid_data  = has_valid_reg;
    assign victim_summary  = victim_summary_reg;
    assign status          = status_reg;

endmodule

FILE: hdl/gcvs_ctrl.sv
`timescale 1ns / 1ps
// gcvs_ctrl: controller state machine sequencing capture, evaluation and result beat
// uses gcvs_pkg command and status structs

module gcvs_ctrl
    import gcvs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  logic         cfg_we,
    output gcvs_cmd_t    cmd,
    input  gcvs_status_t st
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // hold off items while busy or while the quotient is being rebuilt
    assign in_stall      = (state_reg != S_IDLE) || st.div_busy || cfg_we;
    assign cmd.load_item = in_valid && !in_stall;
    assign cmd.eval      = (state_reg == S_EVAL);

    // state and registered result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load_item)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (st.emit)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/flash_gc_victim_selector.sv
`timescale 1ns / 1ps
// Greedy garbage-collection victim selector: one area per input beat, at most one
// result beat per scan. Each area is captured, then evaluated; an area that
// produces a result also holds a result beat, which must be taken before the next
// area is accepted. After any configuration write the input stalls while a
// one-bit-per-cycle divider rebuilds the wear average (overall_deletions /
// area_count). Depends on gcvs_pkg, gcvs_ctrl, gcvs_datapath and gcvs_div.

module flash_gc_victim_selector
    import gcvs_pkg::*;
#(
    parameter int PAGES_PER_AREA = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // area beats
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [AREA_W-1:0]    area_index,
    input  logic                 is_active,
    input  logic [TYPE_W-1:0]    area_type,
    input  logic [COUNT32_W-1:0] erase_count,
    input  logic [SUM_W-1:0]     page_summary,
    input  logic                 summary_written,
    input  logic                 should_clear,
    input  logic                 load_error,
    input  logic                 last_area,
    // result beats
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [AREA_W-1:0]    victim_area,
    output logic                 has_valid_data,
    output logic [SUM_W-1:0]     victim_summary,
    output logic                 status
);

    gcvs_cmd_t    cmd;
    gcvs_status_t st;

    // sequencing
    gcvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cmd       (cmd),
        .st        (st)
    );

    // selection datapath
    gcvs_datapath #(
        .PAGES_PER_AREA (PAGES_PER_AREA)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .area_index      (area_index),
        .is_active       (is_active),
        .area_type       (area_type),
        .erase_count     (erase_count),
        .page_summary    (page_summary),
        .summary_written (summary_written),
        .should_clear    (should_clear),
        .load_error      (load_error),
        .last_area       (last_area),
        .victim_area     (victim_area),
        .has_valid_data  (has_valid_data),
        .victim_summary  (victim_summary),
        .status          (status)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench for flash_gc_victim_selector: area beats in, victim beats out, checked
// against a cycle-free predictor kept in a small scoreboard class
// depends on gcvs_pkg and the flash_gc_victim_selector top level

module testbench;
    import gcvs_pkg::*;

    localparam int PAGES           = 32;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 178;

    // codes the package leaves out
    localparam logic [TYPE_W-1:0] TYPE_OTHER = 2'd3;
    localparam logic [1:0]        PAGE_FREE  = 2'd0;
    localparam logic [1:0]        PAGE_OTHER = 2'd3;

    localparam logic [SUM_W-1:0] PAGE_BITS  =
        (PAGES >= 32) ? {SUM_W{1'b1}} : ((64'd1 << (2 * PAGES)) - 64'd1);
    localparam logic [SUM_W-1:0] FULL_DIRTY = {PAGES{PAGE_DIRTY}};

    typedef struct {
        logic [AREA_W-1:0]    index;
        logic                 active;
        logic [TYPE_W-1:0]    kind;
        logic [COUNT32_W-1:0] erases;
        logic [SUM_W-1:0]     summary;
        logic                 written;
        logic                 clear;
        logic                 load_err;
        logic                 last;
    } area_beat_t;

    typedef struct {
        logic [AREA_W-1:0] area;
        logic              valid_data;
        logic [SUM_W-1:0]  summary;
        logic              status;
    } victim_t;

    // greedy victim predictor plus the queue of victims still owed by the block
    class victim_scoreboard;
        logic [TYPE_W-1:0]    target;
        logic [31:0]          deletions;
        logic [ACNT_W-1:0]    areas;
        logic [AREA_W-1:0]    best_area;
        logic [DIRTY_W-1:0]   best_dirty;
        logic [31:0]          best_erases;
        logic                 best_valid;
        logic [SUM_W-1:0]     best_summary;
        logic                 decided;
        bit                   scan_has_victim;
        victim_t              pending[$];
        int                   mismatches;
        int                   results_seen;
        int                   beats_seen;
        int                   scan_ends;
        int                   early_ends;
        int                   load_errors;

        function new();
            target     = TARGET_RESET;
            deletions  = '0;
            areas      = ACOUNT_RESET;
            mismatches = 0;
            results_seen = 0;
            beats_seen = 0;
            scan_ends  = 0;
            early_ends = 0;
            load_errors = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            best_area       = '0;
            best_dirty      = '0;
            best_erases     = '1;
            best_valid      = 1'b0;
            best_summary    = '0;
            decided         = 1'b0;
            scan_has_victim = 1'b0;
        endfunction

        function void set_config(logic [TYPE_W-1:0] t, logic [31:0] od, logic [ACNT_W-1:0] ac);
            target    = t;
            deletions = od;
            areas     = ac;
        endfunction

        // wear average; a zero divisor reads as all ones
        function logic [31:0] wear_quotient();
            if (areas == '0)
                return '1;
            return deletions / {21'b0, areas};
        endfunction

        function void queue_victim(logic [AREA_W-1:0] a, logic v, logic [SUM_W-1:0] s,
                                   logic st);
            victim_t r;
            r.area       = a;
            r.valid_data = v;
            r.summary    = s;
            r.status     = st;
            pending.push_back(r);
        endfunction

        function void note_area(area_beat_t b);
            logic [SUM_W-1:0] s;
            logic [1:0]       code;
            int               p;
            int               dirty;
            int               used;
            bit               take;
            s     = b.summary & PAGE_BITS;
            dirty = 0;
            used  = 0;
            take  = 1'b0;
            beats_seen++;
            // once decided, only the closing beat matters
            if (decided)
            begin
                if (b.last)
                    restart_scan();
                return;
            end
            if (!b.active && (b.kind == TYPE_DATA || b.kind == TYPE_INDEX))
            begin
                if (b.load_err)
                begin
                    queue_victim('0, 1'b0, '0, STATUS_LOAD_ERR);
                    load_errors++;
                    if (b.last)
                        restart_scan();
                    else
                        decided = 1'b1;
                    return;
                end
                for (p = 0; p < PAGES; p++)
                begin
                    code = s[2*p +: 2];
                    if (code == PAGE_DIRTY)
                        dirty++;
                    else if (code == PAGE_USED)
                        used++;
                end
                if (target != TYPE_UNSET)
                begin
                    // fully dirty area that passes the wear check ends the scan
                    if (dirty == PAGES &&
                        ({21'b0, areas} > deletions || b.erases < wear_quotient()))
                    begin
                        queue_victim(b.index, 1'b0, s, STATUS_OK);
                        early_ends++;
                        if (b.last)
                            restart_scan();
                        else
                            decided = 1'b1;
                        return;
                    end
                    if (b.kind == target)
                    begin
                        take = dirty > best_dirty ||
                               (dirty != 0 && dirty == best_dirty &&
                                (b.erases < best_erases || b.written));
                        if (take)
                            best_erases = b.erases;
                    end
                end
                else
                begin
                    take = b.clear && dirty >= best_dirty;
                end
                if (take)
                begin
                    best_area       = b.index;
                    best_dirty      = dirty[DIRTY_W-1:0];
                    best_valid      = used > 0;
                    best_summary    = s;
                    scan_has_victim = 1'b1;
                end
            end
            if (b.last)
            begin
                queue_victim(best_area, best_valid, best_summary, STATUS_OK);
                scan_ends++;
                restart_scan();
            end
        endfunction

        function void check_result(victim_t got);
            victim_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                $display("%0t: victim beat with none expected: area %0d status %0b",
                         $time, got.area, got.status);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.area !== want.area)
            begin
                $display("%0t: victim_area expected %0d actual %0d", $time, want.area, got.area);
                mismatches++;
            end
            if (got.valid_data !== want.valid_data)
            begin
                $display("%0t: has_valid_data expected %0b actual %0b",
                         $time, want.valid_data, got.valid_data);
                mismatches++;
            end
            if (got.summary !== want.summary)
            begin
                $display("%0t: victim_summary expected %h actual %h",
                         $time, want.summary, got.summary);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [AREA_W-1:0]    area_index = '0;
    logic                 is_active = 1'b0;
    logic [TYPE_W-1:0]    area_type = '0;
    logic [COUNT32_W-1:0] erase_count = '0;
    logic [SUM_W-1:0]     page_summary = '0;
    logic                 summary_written = 1'b0;
    logic                 should_clear = 1'b0;
    logic                 load_error = 1'b0;
    logic                 last_area = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [AREA_W-1:0]    victim_area;
    logic                 has_valid_data;
    logic [SUM_W-1:0]     victim_summary;
    logic                 status;

    victim_scoreboard sb = new();
    victim_t          seen_result;
    int               cycle_count = 0;
    int               burst_left = 0;
    int               settings_used = 0;
    int               hold_offs = 0;
    bit               hold_off_req = 1'b0;

    flash_gc_victim_selector #(.PAGES_PER_AREA(PAGES)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .area_index     (area_index),
        .is_active      (is_active),
        .area_type      (area_type),
        .erase_count    (erase_count),
        .page_summary   (page_summary),
        .summary_written(summary_written),
        .should_clear   (should_clear),
        .load_error     (load_error),
        .last_area      (last_area),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .victim_area    (victim_area),
        .has_valid_data (has_valid_data),
        .victim_summary (victim_summary),
        .status         (status)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("%0t: run stopped after %0d cycles", $time, LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // victim beats taken at the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            seen_result.area       = victim_area;
            seen_result.valid_data = has_valid_data;
            seen_result.summary    = victim_summary;
            seen_result.status     = status;
            sb.check_result(seen_result);
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : result_sink
        int mode;
        int span;
        forever
        begin
            if (hold_off_req)
            begin
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_off_req = 1'b0;
                hold_offs++;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic area_beat_t make_beat(logic [AREA_W-1:0] idx, logic act,
                                             logic [TYPE_W-1:0] kind,
                                             logic [COUNT32_W-1:0] erases,
                                             logic [SUM_W-1:0] summary, logic written,
                                             logic clear, logic lerr, logic last);
        area_beat_t b;
        b.index    = idx;
        b.active   = act;
        b.kind     = kind;
        b.erases   = erases;
        b.summary  = summary;
        b.written  = written;
        b.clear    = clear;
        b.load_err = lerr;
        b.last     = last;
        return b;
    endfunction

    // first pages dirty, next ones used, rest free
    function automatic logic [SUM_W-1:0] pack_pages(int dirty, int used);
        logic [SUM_W-1:0] s;
        int               p;
        s = '0;
        for (p = 0; p < dirty + used && p < PAGES; p++)
            s[2*p +: 2] = (p < dirty) ? PAGE_DIRTY : PAGE_USED;
        return s;
    endfunction

    // summaries lean toward nearly full dirty areas so that ties happen
    function automatic logic [SUM_W-1:0] random_summary();
        logic [SUM_W-1:0] s;
        int               pick;
        int               pg;
        logic [1:0]       code;
        pick = $urandom_range(0, 15);
        if (pick < 2)
            s = FULL_DIRTY;
        else if (pick < 8)
        begin
            s = FULL_DIRTY;
            repeat ($urandom_range(1, 3))
            begin
                pg = $urandom_range(0, PAGES - 1);
                case ($urandom_range(0, 2))
                    0: code = PAGE_FREE;
                    1: code = PAGE_USED;
                    default: code = PAGE_OTHER;
                endcase
                s[2*pg +: 2] = code;
            end
        end
        else if (pick < 14)
            s = {$urandom, $urandom};
        else if (pick == 14)
            s = '0;
        else
            s = '1;
        return s;
    endfunction

    function automatic area_beat_t random_area(bit last);
        area_beat_t  b;
        logic [31:0] q;
        q = sb.wear_quotient();
        b.index  = AREA_W'($urandom_range(0, 1023));
        b.active = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) != 0)
            b.kind = (sb.target == TYPE_DATA || sb.target == TYPE_INDEX) ?
                     sb.target : TYPE_W'($urandom_range(1, 2));
        else
            b.kind = TYPE_W'($urandom_range(0, 3));
        // erase counts around the wear average
        case ($urandom_range(0, 6))
            0: b.erases = '0;
            1: b.erases = q - 1;
            2: b.erases = q;
            3: b.erases = q + 1;
            4: b.erases = '1;
            5: b.erases = $urandom_range(0, 63);
            default: b.erases = $urandom;
        endcase
        b.summary  = random_summary();
        b.written  = 1'($urandom_range(0, 1));
        b.clear    = 1'($urandom_range(0, 1));
        b.load_err = ($urandom_range(0, 39) == 0);
        b.last     = last;
        // a scan never closes on a best summary that was not written
        if (last && !sb.decided && !sb.scan_has_victim)
        begin
            b.active   = 1'b0;
            b.kind     = TYPE_DATA;
            b.load_err = 1'b0;
            b.clear    = 1'b1;
            if (sb.target != TYPE_UNSET)
            begin
                b.summary = FULL_DIRTY;
                b.erases  = '0;
            end
        end
        return b;
    endfunction

    // offer one area beat, in bursts with random gaps
    task automatic send_area(area_beat_t b);
        if (burst_left == 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid        <= 1'b1;
        area_index      <= b.index;
        is_active       <= b.active;
        area_type       <= b.kind;
        erase_count     <= b.erases;
        page_summary    <= b.summary;
        summary_written <= b.written;
        should_clear    <= b.clear;
        load_error      <= b.load_err;
        last_area       <= b.last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_area(b);
    endtask

    // stop offering and wait for every owed victim, then let the pipe settle
    task automatic drain(int settle);
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic load_config(logic [TYPE_W-1:0] t, logic [31:0] od, logic [ACNT_W-1:0] ac);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TARGET_TYPE;
        cfg_data  <= {{(CFG_DAT_W-TYPE_W){1'b0}}, t};
        @(posedge clk);
        cfg_index <= REG_OVERALL_DEL;
        cfg_data  <= od;
        @(posedge clk);
        cfg_index <= REG_AREA_COUNT;
        cfg_data  <= {{(CFG_DAT_W-ACNT_W){1'b0}}, ac};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(t, od, ac);
        settings_used++;
    endtask

    // whole scans of random length until the beat budget is spent
    task automatic run_phase(int n_items);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            for (k = 0; k < len; k++)
                send_area(random_area(k == len - 1));
            sent += len;
        end
    endtask

    initial
    begin : stimulus
        int                ph;
        logic [TYPE_W-1:0] t;
        logic [31:0]       od;
        logic [ACNT_W-1:0] ac;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // best by dirty count, erase-count tie, written tie, ignored areas
        send_area(make_beat(10'd5, 1'b0, TYPE_DATA, 32'd10, pack_pages(3, 2),
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd7, 1'b0, TYPE_DATA, 32'd5, pack_pages(3, 0),
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd9, 1'b0, TYPE_DATA, 32'd20, pack_pages(3, 1),
                            1'b1, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd8, 1'b0, TYPE_DATA, 32'd30, pack_pages(3, 0),
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd11, 1'b0, TYPE_INDEX, 32'd0, pack_pages(20, 0),
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd12, 1'b1, TYPE_DATA, 32'd0, FULL_DIRTY,
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd13, 1'b0, TYPE_OTHER, 32'd0, FULL_DIRTY,
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd14, 1'b0, TYPE_UNSET, 32'd0, FULL_DIRTY,
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd1023, 1'b0, TYPE_DATA, '1, pack_pages(4, 5),
                            1'b0, 1'b0, 1'b0, 1'b1));
        // early end on a fully dirty area of the other type, then ignored beats
        send_area(make_beat(10'd0, 1'b0, TYPE_INDEX, 32'd3, FULL_DIRTY,
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd20, 1'b0, TYPE_DATA, 32'd0, pack_pages(5, 0),
                            1'b0, 1'b0, 1'b1, 1'b0));
        send_area(make_beat(10'd21, 1'b0, TYPE_DATA, 32'd0, '1,
                            1'b1, 1'b1, 1'b0, 1'b1));
        // zero dirty pages never win a tie, even when written
        send_area(make_beat(10'd30, 1'b0, TYPE_DATA, 32'd0, '1,
                            1'b1, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd31, 1'b0, TYPE_DATA, 32'd7, '0,
                            1'b1, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd32, 1'b0, TYPE_DATA, 32'd3, pack_pages(1, 31),
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd34, 1'b0, TYPE_INDEX, 32'd0, pack_pages(31, 1),
                            1'b0, 1'b0, 1'b0, 1'b1));
        // load error in mid scan
        send_area(make_beat(10'd40, 1'b0, TYPE_DATA, 32'd1, pack_pages(2, 0),
                            1'b0, 1'b0, 1'b0, 1'b0));
        send_area(make_beat(10'd41, 1'b0, TYPE_INDEX, 32'd1, pack_pages(2, 0),
                            1'b0, 1'b0, 1'b1, 1'b0));
        send_area(make_beat(10'd42, 1'b0, TYPE_DATA, 32'd0, FULL_DIRTY,
                            1'b0, 1'b0, 1'b0, 1'b1));
        // load error on non-candidates is ignored, on the closing beat it reports
        send_area(make_beat(10'd50, 1'b1, TYPE_DATA, 32'd0, pack_pages(3, 0),
                            1'b0, 1'b0, 1'b1, 1'b0));
        send_area(make_beat(10'd51, 1'b0, TYPE_OTHER, 32'd0, '0,
                            1'b0, 1'b0, 1'b1, 1'b0));
        send_area(make_beat(10'd52, 1'b0, TYPE_INDEX, 32'd0, pack_pages(1, 0),
                            1'b0, 1'b0, 1'b1, 1'b1));
        // early end on the closing beat
        send_area(make_beat(10'd1023, 1'b0, TYPE_DATA, '1, FULL_DIRTY,
                            1'b1, 1'b1, 1'b0, 1'b1));

        // randomized scans across register settings, extremes first
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    t = TYPE_UNSET; od = 32'd0; ac = 11'd1;
                end
                1:
                begin
                    t = TYPE_DATA; od = '1; ac = 11'd1;
                end
                2:
                begin
                    t = TYPE_INDEX; od = 32'd100000; ac = 11'd1024;
                end
                3:
                begin
                    t = TYPE_OTHER; od = 32'd5000; ac = 11'd0;
                end
                4:
                begin
                    t = TYPE_DATA; od = 32'd2000; ac = 11'd2047;
                end
                default:
                begin
                    t = TYPE_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: od = '0;
                        1: od = '1;
                        2: od = $urandom;
                        default: od = $urandom_range(0, 5000);
                    endcase
                    case ($urandom_range(0, 4))
                        0: ac = 11'd0;
                        1: ac = 11'd1;
                        2: ac = 11'd1024;
                        3: ac = 11'd2047;
                        default: ac = ACNT_W'($urandom_range(1, 1024));
                    endcase
                end
            endcase
            drain(SETTLE_CYCLES);
            load_config(t, od, ac);
            if (ph == 2)
                hold_off_req = 1'b1;
            if (ph == 4)
            begin
                // sender pauses mid-phase until the block owes nothing
                run_phase(ITEMS_PER_PHASE / 2);
                drain(1);
                run_phase(ITEMS_PER_PHASE / 2);
            end
            else
            begin
                run_phase(ITEMS_PER_PHASE);
            end
        end
        drain(SETTLE_CYCLES * 3);

        $display("run covered %0d area beats over %0d register settings plus reset values",
                 sb.beats_seen, settings_used);
        $display("victims checked %0d: %0d scan ends, %0d early ends, %0d load errors, %0d long receiver hold-offs",
                 sb.results_seen, sb.scan_ends, sb.early_ends, sb.load_errors, hold_offs);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
